FILE: design/assert_macros.svh
// assertion macros shared by the pixel converter modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define AM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define AM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/mp8_pkg.sv
// types and constants of the masked pixel to rgba8 converter
`timescale 1ns / 1ps
`default_nettype none

package mp8_pkg;

	localparam int unsigned WORD_W   = 32;
	localparam int unsigned QUO_W    = 8;
	localparam int unsigned PROD_W   = WORD_W + QUO_W;
	localparam int unsigned NUM_CH   = 4;
	localparam int unsigned FRONT_STAGES = 2;
	localparam int unsigned NUM_STAGES   = FRONT_STAGES + QUO_W;

	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 2;
	localparam int unsigned CH_ALPHA = 3;

	localparam logic [QUO_W-1:0] CHAN_MAX = 8'd255;

	// pixel size codes
	localparam logic [5:0] PIX_BITS_DEF = 6'd0;
	localparam logic [5:0] PIX_BITS_16  = 6'd16;
	localparam logic [5:0] PIX_BITS_24  = 6'd24;
	localparam logic [5:0] PIX_BITS_32  = 6'd32;

	localparam logic [WORD_W-1:0] MASK_24 = 32'h00FF_FFFF;
	localparam logic [WORD_W-1:0] MASK_16 = 32'h0000_FFFF;

	// reset values of the registers
	localparam logic [WORD_W-1:0] RST_RED_MASK   = 32'h00FF_0000;
	localparam logic [WORD_W-1:0] RST_GREEN_MASK = 32'h0000_FF00;
	localparam logic [WORD_W-1:0] RST_BLUE_MASK  = 32'h0000_00FF;
	localparam logic [WORD_W-1:0] RST_ALPHA_MASK = 32'hFF00_0000;

	typedef enum logic [2:0] {
		CFG_PIXEL_BITS   = 3'd0,
		CFG_RED_MASK     = 3'd1,
		CFG_GREEN_MASK   = 3'd2,
		CFG_BLUE_MASK    = 3'd3,
		CFG_ALPHA_MASK   = 3'd4,
		CFG_ALPHA_ENABLE = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [5:0]                        pixel_bits;
		logic [NUM_CH-1:0][WORD_W-1:0]     mask;
		logic                              alpha_enable;
	} cfg_t;

	// one channel on its way through the divider
	typedef struct packed {
		logic [PROD_W-1:0] rem;
		logic [WORD_W-1:0] div;
		logic [QUO_W-1:0]  q;
		logic              sat;
	} chan_t;

	typedef struct packed {
		chan_t [NUM_CH-1:0] ch;
		logic               last;
	} pix_t;

endpackage

`default_nettype wire

FILE: design/mp8_pix_if.sv
// input channel carrying raw pixel words
`timescale 1ns / 1ps
`default_nettype none

interface mp8_pix_if;
	logic                        valid;
	logic                        ready;
	logic [mp8_pkg::WORD_W-1:0]  pixel_word;
	logic                        last_in;

	modport source (output valid, output pixel_word, output last_in, input ready);
	modport sink   (input valid, input pixel_word, input last_in, output ready);
endinterface

`default_nettype wire

FILE: design/mp8_rgba_if.sv
// output channel carrying rgba8 words
`timescale 1ns / 1ps
`default_nettype none

interface mp8_rgba_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic [7:0] alpha_out;
	logic       last_out;

	modport source (output valid, output red_out, output green_out, output blue_out,
		output alpha_out, output last_out, input ready);
	modport sink   (input valid, input red_out, input green_out, input blue_out,
		input alpha_out, input last_out, output ready);
endinterface

`default_nettype wire

FILE: design/mp8_cfg_if.sv
// register write channel
`timescale 1ns / 1ps
`default_nettype none

interface mp8_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  index;
	logic [mp8_pkg::WORD_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/mp8_front.sv
// byte select, channel masking and dividend setup (stages 1 and 2)
`timescale 1ns / 1ps
`default_nettype none

module mp8_front (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en_s1,
	input  wire logic                        en_s2,
	input  wire logic                        in_valid,
	input  wire logic [mp8_pkg::WORD_W-1:0]  pixel_word,
	input  wire logic                        last_in,
	input  wire mp8_pkg::cfg_t               cfg,
	output      logic                        vld_s1,
	output      logic                        vld_s2,
	output      mp8_pkg::pix_t               data_s2
);

	// lowest run of ones of a mask, left in place
	function automatic logic [mp8_pkg::WORD_W-1:0] low_run(
		input logic [mp8_pkg::WORD_W-1:0] m
	);
		logic [mp8_pkg::WORD_W-1:0] lsb;
		logic [mp8_pkg::WORD_W:0]   sum;
		lsb = m & (~m + mp8_pkg::WORD_W'(1));
		sum = {1'b0, m} + {1'b0, lsb};
		return m & ~sum[mp8_pkg::WORD_W-1:0];
	endfunction

	logic [mp8_pkg::WORD_W-1:0]                       sel_word;
	logic [mp8_pkg::NUM_CH-1:0][mp8_pkg::WORD_W-1:0]  mv_nxt;
	logic [mp8_pkg::NUM_CH-1:0][mp8_pkg::WORD_W-1:0]  run_nxt;
	logic [mp8_pkg::NUM_CH-1:0]                       force_nxt;

	logic [mp8_pkg::NUM_CH-1:0][mp8_pkg::WORD_W-1:0]  mv_s1;
	logic [mp8_pkg::NUM_CH-1:0][mp8_pkg::WORD_W-1:0]  run_s1;
	logic [mp8_pkg::NUM_CH-1:0]                       force_s1;
	logic                                             last_s1;

	mp8_pkg::pix_t s2_nxt;

	always_comb begin
		unique case (cfg.pixel_bits)
			mp8_pkg::PIX_BITS_DEF, mp8_pkg::PIX_BITS_32: sel_word = pixel_word;
			mp8_pkg::PIX_BITS_24: sel_word = pixel_word & mp8_pkg::MASK_24;
			mp8_pkg::PIX_BITS_16: sel_word = pixel_word & mp8_pkg::MASK_16;
			default:              sel_word = '0;
		endcase
		for (int c = 0; c < mp8_pkg::NUM_CH; c++) begin
			mv_nxt[c]    = sel_word & cfg.mask[c];
			run_nxt[c]   = low_run(cfg.mask[c]);
			force_nxt[c] = (cfg.mask[c] == '0);
		end
		if (!cfg.alpha_enable) begin
			force_nxt[mp8_pkg::CH_ALPHA] = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			mv_s1    <= mv_nxt;
			run_s1   <= run_nxt;
			force_s1 <= force_nxt;
			last_s1  <= last_in;
		end
	end

	// dividend 255 * value; a value above the run, an empty mask or alpha off saturates
	always_comb begin
		s2_nxt.last = last_s1;
		for (int c = 0; c < mp8_pkg::NUM_CH; c++) begin
			s2_nxt.ch[c].rem = {mv_s1[c], mp8_pkg::QUO_W'(0)}
				- mp8_pkg::PROD_W'(mv_s1[c]);
			s2_nxt.ch[c].div = run_s1[c];
			s2_nxt.ch[c].q   = '0;
			s2_nxt.ch[c].sat = force_s1[c] | (mv_s1[c] > run_s1[c]);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2) data_s2 <= s2_nxt;
	end

endmodule

`default_nettype wire

FILE: design/mp8_div_step.sv
// one restoring divide step for all four channels, one register stage
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module mp8_div_step #(
	parameter int unsigned BIT = 7
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            en,
	input  wire logic            in_valid,
	input  wire mp8_pkg::pix_t   data_in,
	output      logic            vld_s,
	output      mp8_pkg::pix_t   data_s
);

	logic [mp8_pkg::NUM_CH-1:0][mp8_pkg::PROD_W-1:0] dsh;
	mp8_pkg::pix_t d_nxt;

	always_comb begin
		d_nxt = data_in;
		for (int c = 0; c < mp8_pkg::NUM_CH; c++) begin
			dsh[c] = mp8_pkg::PROD_W'(data_in.ch[c].div) << BIT;
			if (data_in.ch[c].rem >= dsh[c]) begin
				d_nxt.ch[c].rem    = data_in.ch[c].rem - dsh[c];
				d_nxt.ch[c].q[BIT] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= 1'b0;
		end else if (en) begin
			vld_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) data_s <= d_nxt;
	end

	// red remainder stays below the shifted divisor once this bit is settled, unless saturated
	`AM_ASSERT_IMP(a_rem_bound, vld_s && !data_s.ch[mp8_pkg::CH_RED].sat,
		data_s.ch[mp8_pkg::CH_RED].rem < (mp8_pkg::PROD_W'(data_s.ch[mp8_pkg::CH_RED].div) << BIT),
		"divide step left remainder above divisor")

endmodule

`default_nettype wire

FILE: design/masked_pixel_to_rgba8_core.sv
// top level of the masked pixel to rgba8 converter
// usage:
//   in_pix  : raw pixel words (pixel_word, last_in), valid/ready handshake
//   out_pix : rgba8 words (red/green/blue/alpha_out, last_out), valid/ready
//   cfg     : register writes (index, data); always ready, writes land at once
//   registers: 0 pixel_bits, 1..4 red/green/blue/alpha masks, 5 alpha_enable
//   change registers only while no word is in flight
// timing:
//   ten register stages; the accepting edge loads stage 1, the word shows on
//   out_pix from stage 10; one word per cycle while out_pix is not stalled
//   stages 1-2 pick bytes, mask and build 255*value, stages 3-10 each settle
//   one quotient bit with a 40-bit compare and subtract per channel
// reset: all stage valid bits clear, registers take their default format
//   (32-bit pixels, argb8888 masks, alpha on)
// stall: each stage holds while the one after it is full and stalled, so
//   bubbles close up; in_pix.ready drops only when every stage holds a word
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module masked_pixel_to_rgba8_core (
	input  wire logic   clk,
	input  wire logic   arst_n,
	mp8_pix_if.sink     in_pix,
	mp8_rgba_if.source  out_pix,
	mp8_cfg_if.sink     cfg
);

	mp8_pkg::cfg_t cfg_q;

	logic [mp8_pkg::NUM_STAGES-1:0] stage_vld;
	logic [mp8_pkg::NUM_STAGES-1:0] stage_en;

	// divider data between steps, entry 0 comes from the front end
	mp8_pkg::pix_t div_d [mp8_pkg::QUO_W+1];
	mp8_pkg::pix_t fin;

	// register file, writes to unknown indexes are dropped
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_bits                  <= mp8_pkg::PIX_BITS_32;
			cfg_q.mask[mp8_pkg::CH_RED]       <= mp8_pkg::RST_RED_MASK;
			cfg_q.mask[mp8_pkg::CH_GREEN]     <= mp8_pkg::RST_GREEN_MASK;
			cfg_q.mask[mp8_pkg::CH_BLUE]      <= mp8_pkg::RST_BLUE_MASK;
			cfg_q.mask[mp8_pkg::CH_ALPHA]     <= mp8_pkg::RST_ALPHA_MASK;
			cfg_q.alpha_enable                <= 1'b1;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				mp8_pkg::CFG_PIXEL_BITS:   cfg_q.pixel_bits <= cfg.data[5:0];
				mp8_pkg::CFG_RED_MASK:     cfg_q.mask[mp8_pkg::CH_RED] <= cfg.data;
				mp8_pkg::CFG_GREEN_MASK:   cfg_q.mask[mp8_pkg::CH_GREEN] <= cfg.data;
				mp8_pkg::CFG_BLUE_MASK:    cfg_q.mask[mp8_pkg::CH_BLUE] <= cfg.data;
				mp8_pkg::CFG_ALPHA_MASK:   cfg_q.mask[mp8_pkg::CH_ALPHA] <= cfg.data;
				mp8_pkg::CFG_ALPHA_ENABLE: cfg_q.alpha_enable <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or the stage after it moves
	always_comb begin
		stage_en[mp8_pkg::NUM_STAGES-1] = !stage_vld[mp8_pkg::NUM_STAGES-1] | out_pix.ready;
		for (int i = mp8_pkg::NUM_STAGES - 2; i >= 0; i--) begin
			stage_en[i] = !stage_vld[i] | stage_en[i+1];
		end
	end

	assign in_pix.ready = stage_en[0];

	mp8_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en_s1      (stage_en[0]),
		.en_s2      (stage_en[1]),
		.in_valid   (in_pix.valid),
		.pixel_word (in_pix.pixel_word),
		.last_in    (in_pix.last_in),
		.cfg        (cfg_q),
		.vld_s1     (stage_vld[0]),
		.vld_s2     (stage_vld[1]),
		.data_s2    (div_d[0])
	);

	// quotient bits msb first, one stage each
	for (genvar k = 0; k < mp8_pkg::QUO_W; k++) begin : g_div
		mp8_div_step #(
			.BIT (mp8_pkg::QUO_W - 1 - k)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (stage_en[mp8_pkg::FRONT_STAGES + k]),
			.in_valid (stage_vld[mp8_pkg::FRONT_STAGES + k - 1]),
			.data_in  (div_d[k]),
			.vld_s    (stage_vld[mp8_pkg::FRONT_STAGES + k]),
			.data_s   (div_d[k+1])
		);
	end

	// last divide stage doubles as the output register
	assign fin           = div_d[mp8_pkg::QUO_W];
	assign out_pix.valid = stage_vld[mp8_pkg::NUM_STAGES-1];

	always_comb begin
		out_pix.red_out   = fin.ch[mp8_pkg::CH_RED].sat ? mp8_pkg::CHAN_MAX
			: fin.ch[mp8_pkg::CH_RED].q;
		out_pix.green_out = fin.ch[mp8_pkg::CH_GREEN].sat ? mp8_pkg::CHAN_MAX
			: fin.ch[mp8_pkg::CH_GREEN].q;
		out_pix.blue_out  = fin.ch[mp8_pkg::CH_BLUE].sat ? mp8_pkg::CHAN_MAX
			: fin.ch[mp8_pkg::CH_BLUE].q;
		out_pix.alpha_out = fin.ch[mp8_pkg::CH_ALPHA].sat ? mp8_pkg::CHAN_MAX
			: fin.ch[mp8_pkg::CH_ALPHA].q;
		out_pix.last_out  = fin.last;
	end

	// an accepted word always lands in the first stage
	`AM_ASSERT_NXT(a_in_lands, in_pix.valid && in_pix.ready, stage_vld[0],
		"accepted word did not enter stage 1")

	// alpha off forces full alpha
	`AM_ASSERT_IMP(a_alpha_off, out_pix.valid && !cfg_q.alpha_enable,
		out_pix.alpha_out == mp8_pkg::CHAN_MAX, "alpha not forced to full")

	// empty red mask reads full
	`AM_ASSERT_IMP(a_red_empty, out_pix.valid && (cfg_q.mask[mp8_pkg::CH_RED] == '0),
		out_pix.red_out == mp8_pkg::CHAN_MAX, "empty red mask not full")

endmodule

`default_nettype wire
